### hw/rtl/sdnv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdnv_pkg;

  // Value width and 7-bit grouping
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int unsigned OCT_W      = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned GIDX_W     = $clog2(MAX_GROUPS);
  localparam int unsigned SHIFT_W    = $clog2(VALUE_BITS);
  localparam int unsigned CONT_POS   = 7;
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = ((VALUE_BITS + OCT_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W   = OCT_W + VALUE_BITS + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_DEC_OUT
  } state_e;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef enum logic {
    KIND_OCTET = 1'b0,
    KIND_VALUE = 1'b1
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic enc_load;   // latch value, compute octet count
    logic enc_emit;   // push next encoded octet
    logic dec_step;   // shift received group into accumulator
    logic dec_emit;   // push decoded value, clear decode state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic group_zero;   // encoder is at the least significant group
    logic octet_final;  // incoming octet has bit 7 clear
  } stat_t;

  // Clamp the register to 1..MAX_GROUPS
  function automatic logic [CNT_W-1:0] octet_limit(input logic [CNT_W-1:0] max_octets);
    logic [CNT_W-1:0] lim;
    lim = max_octets;
    if (lim == '0) begin
      lim = CNT_W'(1);
    end
    if (lim > CNT_W'(MAX_GROUPS)) begin
      lim = CNT_W'(MAX_GROUPS);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sdnv_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Ports                        | Transaction
// ----------+-----------+------------------------------+------------------------------------
// s_axis    | in        | tvalid/tready/tdata/tuser    | one encode value or one decode octet
// m_axis    | out       | tvalid/tready/tdata/tuser/tlast | one encoded octet or decoded value
// cfg       | in        | cfg_valid/cfg_ready/cfg_data | write of max_octets (always ready)
//
// Encode: the value is accepted, then its octets are emitted in turn; the single group
// selector in the datapath emits one octet a cycle while m_axis is not stalled.
// Decode: each octet is shifted into the accumulator; a final octet adds a result load.
// Reset clears the accumulator, the octet count and the overflow flag, and sets
// max_octets to 10. A stalled m_axis holds the result register; s_axis is still
// accepted in idle while a result waits, then the block stalls on its next result.

module sdnv_codec (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input stream
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [63:0] value, [71:64] octet
  input  wire logic [sdnv_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [0] action
  input  wire logic                                 s_axis_tuser_i,
  // Output stream
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // [7:0] out_octet, [71:8] out_value, [72] error, [79:73] zero
  output logic [sdnv_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o,
  // [0] kind
  output logic                                      m_axis_tuser_o,
  output logic                                      m_axis_tlast_o,
  // Configuration
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [sdnv_pkg::CNT_W-1:0]           cfg_data_i
);

  localparam int unsigned VB = sdnv_pkg::VALUE_BITS;
  localparam int unsigned OW = sdnv_pkg::OCT_W;

  sdnv_pkg::cmd_t  cmd;
  sdnv_pkg::stat_t stat;

  logic          in_accept;
  logic          out_kind;
  logic [OW-1:0] out_octet;
  logic [VB-1:0] out_value;
  logic          out_error;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;

  // Sequence encode octets and decode results
  sdnv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Group splitter, accumulator and result register
  sdnv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_value_i  (s_axis_tdata_i[VB-1:0]),
    .in_octet_i  (s_axis_tdata_i[VB+OW-1:VB]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_kind_o  (out_kind),
    .out_octet_o (out_octet),
    .out_value_o (out_value),
    .out_error_o (out_error),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack result fields, pad to whole bytes
  assign m_axis_tdata_o = {(sdnv_pkg::OUT_TDATA_W - sdnv_pkg::OUT_RAW_W)'(0),
                           out_error, out_value, out_octet};
  assign m_axis_tuser_o = out_kind;

  // A decoded value is always the only result of its octet
  a_dec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == sdnv_pkg::KIND_VALUE) |-> m_axis_tlast_o)
    else $error("decode result without tlast");

  // Continuation bit of an encoded octet matches its position in the run
  a_enc_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == sdnv_pkg::KIND_OCTET)
      |-> (out_octet[sdnv_pkg::CONT_POS] == !m_axis_tlast_o) && !out_error)
    else $error("encoded octet continuation bit mismatch");

  // An accepted encode blocks input while its octets are produced
  a_enc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (s_axis_tuser_i == sdnv_pkg::ACT_ENCODE) |=> !s_axis_tready_o)
    else $error("input accepted during encode");

  // A final decode octet blocks input until its result is loaded
  a_dec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (s_axis_tuser_i == sdnv_pkg::ACT_DECODE)
      && !s_axis_tdata_i[VB + sdnv_pkg::CONT_POS] |=> !s_axis_tready_o)
    else $error("input accepted before decode result load");

endmodule

`default_nettype wire

### hw/rtl/sdnv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sdnv_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_action_i,
  output logic                       in_ready_o,
  input  wire sdnv_pkg::stat_t       stat_i,
  output sdnv_pkg::cmd_t             cmd_o
);

  sdnv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdnv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sdnv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == sdnv_pkg::ACT_ENCODE) begin
            cmd_o.enc_load = 1'b1;
            state_d        = sdnv_pkg::ST_ENC;
          end else begin
            cmd_o.dec_step = 1'b1;
            if (stat_i.octet_final) begin
              state_d = sdnv_pkg::ST_DEC_OUT;
            end
          end
        end
      end
      sdnv_pkg::ST_ENC: begin
        if (stat_i.out_free) begin
          cmd_o.enc_emit = 1'b1;
          if (stat_i.group_zero) begin
            state_d = sdnv_pkg::ST_IDLE;
          end
        end
      end
      sdnv_pkg::ST_DEC_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.dec_emit = 1'b1;
          state_d        = sdnv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdnv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/sdnv_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sdnv_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sdnv_pkg::cmd_t                    cmd_i,
  output sdnv_pkg::stat_t                        stat_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [sdnv_pkg::CNT_W-1:0]        cfg_data_i,
  input  wire logic [sdnv_pkg::VALUE_BITS-1:0]   in_value_i,
  input  wire logic [sdnv_pkg::OCT_W-1:0]        in_octet_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   out_kind_o,
  output logic [sdnv_pkg::OCT_W-1:0]             out_octet_o,
  output logic [sdnv_pkg::VALUE_BITS-1:0]        out_value_o,
  output logic                                   out_error_o,
  output logic                                   out_last_o
);

  localparam int unsigned VB = sdnv_pkg::VALUE_BITS;
  localparam int unsigned GB = sdnv_pkg::GROUP_BITS;
  localparam int unsigned MG = sdnv_pkg::MAX_GROUPS;

  logic [sdnv_pkg::CNT_W-1:0]  max_q;
  logic [VB-1:0]               acc_q, acc_d;
  logic [sdnv_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;

  logic [VB-1:0]               val_q;
  logic [sdnv_pkg::GIDX_W-1:0] grp_q;

  logic [MG-1:1]               grp_nz;
  logic [sdnv_pkg::CNT_W-1:0]  need, lim, enc_len;
  logic [sdnv_pkg::SHIFT_W-1:0] grp_shift;
  logic [GB-1:0]               grp_bits;
  logic [sdnv_pkg::OCT_W-1:0]  enc_octet;
  logic                        dec_error;

  assign lim = sdnv_pkg::octet_limit(max_q);

  // Octet count of the incoming value: highest nonzero group plus one, clamped to the limit
  always_comb begin
    for (int j = 1; j < MG; j++) begin
      grp_nz[j] = |(in_value_i >> (GB * j));
    end
    need = sdnv_pkg::CNT_W'(1);
    for (int j = 1; j < MG; j++) begin
      if (grp_nz[j]) begin
        need = sdnv_pkg::CNT_W'(j + 1);
      end
    end
    enc_len = (need < lim) ? need : lim;
  end

  // Current group, most significant first
  assign grp_shift = sdnv_pkg::SHIFT_W'(grp_q) * sdnv_pkg::SHIFT_W'(GB);
  assign grp_bits  = GB'(val_q >> grp_shift);
  always_comb begin
    enc_octet = sdnv_pkg::OCT_W'(grp_bits);
    enc_octet[sdnv_pkg::CONT_POS] = (grp_q != '0);
  end

  // Decode accumulate, cleared when the result is emitted
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.dec_step) begin
      ovf_d = ovf_q | (|acc_q[VB-1:VB-GB]);
      acc_d = {acc_q[VB-GB-1:0], in_octet_i[GB-1:0]};
      if (cnt_q != sdnv_pkg::CNT_W'(sdnv_pkg::CNT_MAX)) begin
        cnt_d = cnt_q + sdnv_pkg::CNT_W'(1);
      end
    end else if (cmd_i.dec_emit) begin
      acc_d = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  assign dec_error = ovf_q | (cnt_q > lim);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.enc_emit || cmd_i.dec_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= sdnv_pkg::CNT_W'(MG);
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Encoder working registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.enc_load) begin
      val_q <= in_value_i;
      grp_q <= sdnv_pkg::GIDX_W'(enc_len - sdnv_pkg::CNT_W'(1));
    end else if (cmd_i.enc_emit) begin
      grp_q <= grp_q - sdnv_pkg::GIDX_W'(1);
    end
    if (cmd_i.enc_emit) begin
      out_kind_o  <= sdnv_pkg::KIND_OCTET;
      out_octet_o <= enc_octet;
      out_value_o <= '0;
      out_error_o <= 1'b0;
      out_last_o  <= (grp_q == '0);
    end else if (cmd_i.dec_emit) begin
      out_kind_o  <= sdnv_pkg::KIND_VALUE;
      out_octet_o <= '0;
      out_value_o <= acc_q;
      out_error_o <= dec_error;
      out_last_o  <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.group_zero  = (grp_q == '0);
  assign stat_o.octet_final = !in_octet_i[sdnv_pkg::CONT_POS];

endmodule

`default_nettype wire
